/* src/assert_macros.svh */
// Assertion macros shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge out of reset
`define PNS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define PNS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/pns_pkg.sv */
// Types and constants of the nearest polyline segment block
`timescale 1ns / 1ps
package pns_pkg;

  localparam int unsigned COORD_W    = 16;
  localparam int unsigned IDX_W      = 10;
  localparam int unsigned DIST_W     = 17;
  localparam int unsigned SQ_W       = 34;
  localparam int unsigned QUO_W      = 17;
  localparam int unsigned FIFO_DEPTH = 2;

  // Work handed from the front to the back
  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] vx;
    logic signed [COORD_W-1:0] vy;
    logic signed [COORD_W-1:0] wx;
    logic signed [COORD_W-1:0] wy;
    logic [IDX_W-1:0]          idx;
    logic                      has_seg;
    logic                      last;
    logic                      no_seg;
    logic                      ovf;
  } job_t;

  typedef enum logic [4:0] {
    S_FETCH, S_L2A, S_L2B, S_DOTA, S_DOTB, S_DOTC, S_CLASS,
    S_NUMA, S_NUMB, S_NUMC, S_NINIT, S_DIV, S_OFS,
    S_DIST, S_SQA, S_SQB, S_SQC, S_CMP, S_FIN, S_ROOT, S_DONE
  } back_state_e;

endpackage

/* src/pns_front.sv */
// Front: accepts vertices, tracks count and overflow, issues segment jobs
`timescale 1ns / 1ps
module pns_front import pns_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [COORD_W-1:0] qx_i,
  input  logic signed [COORD_W-1:0] qy_i,
  input  logic signed [COORD_W-1:0] vx_i,
  input  logic signed [COORD_W-1:0] vy_i,
  input  logic                      last_i,
  output logic                      push_o,
  output job_t                      job_o,
  input  logic                      full_i
);

  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);

  logic signed [COORD_W-1:0] prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;
  logic                      ovf_q, ovf_d;
  logic                      take, room, seg;

  assign in_ready_o = !full_i;
  assign take       = in_valid_i && !full_i;
  assign room       = (cnt_q < CNT_W'(MAX_VERTICES));
  assign seg        = room && (cnt_q != '0);

  always_comb begin
    prev_x_d = prev_x_q;
    prev_y_d = prev_y_q;
    cnt_d    = cnt_q;
    ovf_d    = ovf_q;
    if (room) begin
      prev_x_d = vx_i;
      prev_y_d = vy_i;
      cnt_d    = cnt_q + 1'b1;
    end else begin
      ovf_d = 1'b1;
    end
    job_o.px      = qx_i;
    job_o.py      = qy_i;
    job_o.vx      = prev_x_q;
    job_o.vy      = prev_y_q;
    job_o.wx      = vx_i;
    job_o.wy      = vy_i;
    job_o.idx     = IDX_W'(cnt_q - 1'b1);
    job_o.has_seg = seg;
    job_o.last    = last_i;
    job_o.no_seg  = (cnt_d < CNT_W'(2));
    job_o.ovf     = ovf_d;
    push_o        = take && (seg || last_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= '0;
      prev_y_q <= '0;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
    end else if (take) begin
      if (last_i) begin
        prev_x_q <= '0;
        prev_y_q <= '0;
        cnt_q    <= '0;
        ovf_q    <= 1'b0;
      end else begin
        prev_x_q <= prev_x_d;
        prev_y_q <= prev_y_d;
        cnt_q    <= cnt_d;
        ovf_q    <= ovf_d;
      end
    end
  end

endmodule

/* src/pns_fifo.sv */
// Short job queue between front and back
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pns_fifo import pns_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  job_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_pop;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + CNT_W'(push_i) - CNT_W'(do_pop);
    end
  end

  `PNS_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(FIFO_DEPTH), "queue count above depth")
  `PNS_ASSERT_IMP(a_no_overrun, full_o, !push_i, "push into full queue")
  `PNS_ASSERT_IMP(a_pop_valid, pop_i, valid_o, "pop from empty queue")

endmodule

/* src/pns_back.sv */
// Back: segment distance, running minimum and final square root
`timescale 1ns / 1ps
`include "assert_macros.svh"
module pns_back import pns_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  job_t                job_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [DIST_W-1:0]   min_o,
  output logic [IDX_W-1:0]    idx_o,
  output logic                no_seg_o,
  output logic                ovf_o
);

  back_state_e state_q, state_d;

  job_t                 job_q;
  logic signed [16:0]   ex_q, ey_q, fx_q, fy_q, qx_q, qy_q;
  logic signed [17:0]   dx_q, dy_q;
  logic signed [17:0]   mul_a, mul_b;
  logic signed [35:0]   prod_q;
  logic [SQ_W-1:0]      l2_q;
  logic signed [34:0]   dot_q;
  logic                 axis_q;
  logic [49:0]          num_q;
  logic [50:0]          nfull;
  logic [35:0]          rem_q, r_sh;
  logic [QUO_W-1:0]     low_q, quo_q;
  logic [34:0]          den_q, d_q;
  logic [4:0]           cnt_q;
  logic [SQ_W-1:0]      best_q;
  logic [IDX_W-1:0]     bidx_q;
  logic [SQ_W-1:0]      sv_q;
  logic [18:0]          sr_q;
  logic [20:0]          sr_sh, trial;
  logic [DIST_W-1:0]    root_q;
  logic signed [16:0]   e_ax, ofs, v_ax;
  logic [16:0]          mag;
  logic                 clamp_v, clamp_w, div_end, root_end, load_out;

  logic                 out_valid_q;
  logic [DIST_W-1:0]    min_q;
  logic [IDX_W-1:0]     idx_q;
  logic                 no_seg_q, ovf_q;

  assign e_ax     = axis_q ? ey_q : ex_q;
  assign v_ax     = axis_q ? 17'(job_q.vy) : 17'(job_q.vx);
  assign mag      = e_ax[16] ? 17'(-e_ax) : 17'(e_ax);
  assign ofs      = e_ax[16] ? -$signed(quo_q) : $signed(quo_q);
  assign clamp_v  = (l2_q == '0) || dot_q[34] || (dot_q == '0);
  assign clamp_w  = !dot_q[34] && (dot_q[33:0] >= l2_q);
  assign nfull    = {num_q, 1'b0} + 51'(l2_q);
  assign r_sh     = {rem_q[34:0], low_q[QUO_W-1]};
  assign sr_sh    = {sr_q, sv_q[SQ_W-1 -: 2]};
  assign trial    = {2'b00, root_q, 2'b01};
  assign div_end  = (cnt_q == 5'(QUO_W - 1));
  assign root_end = (cnt_q == 5'(DIST_W - 1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_FETCH: if (valid_i) state_d = job_i.has_seg ? S_L2A : S_FIN;
      S_L2A:   state_d = S_L2B;
      S_L2B:   state_d = S_DOTA;
      S_DOTA:  state_d = S_DOTB;
      S_DOTB:  state_d = S_DOTC;
      S_DOTC:  state_d = S_CLASS;
      S_CLASS: state_d = (clamp_v || clamp_w) ? S_DIST : S_NUMA;
      S_NUMA:  state_d = S_NUMB;
      S_NUMB:  state_d = S_NUMC;
      S_NUMC:  state_d = S_NINIT;
      S_NINIT: state_d = S_DIV;
      S_DIV:   if (div_end) state_d = S_OFS;
      S_OFS:   state_d = axis_q ? S_DIST : S_NUMA;
      S_DIST:  state_d = S_SQA;
      S_SQA:   state_d = S_SQB;
      S_SQB:   state_d = S_SQC;
      S_SQC:   state_d = S_CMP;
      S_CMP:   state_d = S_FIN;
      S_FIN: begin
        if (!job_q.last)       state_d = S_FETCH;
        else if (job_q.no_seg) state_d = S_DONE;
        else                   state_d = S_ROOT;
      end
      S_ROOT:  if (root_end) state_d = S_DONE;
      S_DONE:  if (load_out) state_d = S_FETCH;
      default: state_d = S_FETCH;
    endcase
  end

  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      S_FETCH: pop_o = valid_i;
      S_L2A:   begin mul_a = 18'(ex_q); mul_b = 18'(ex_q); end
      S_L2B:   begin mul_a = 18'(ey_q); mul_b = 18'(ey_q); end
      S_DOTA:  begin mul_a = 18'(fx_q); mul_b = 18'(ex_q); end
      S_DOTB:  begin mul_a = 18'(fy_q); mul_b = 18'(ey_q); end
      S_NUMA:  begin mul_a = {1'b0, mag}; mul_b = {1'b0, dot_q[16:0]}; end
      S_NUMB:  begin mul_a = {1'b0, mag}; mul_b = {1'b0, dot_q[33:17]}; end
      S_SQA:   begin mul_a = dx_q; mul_b = dx_q; end
      S_SQB:   begin mul_a = dy_q; mul_b = dy_q; end
      S_DONE:  load_out = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    unique case (state_q)
      S_FETCH: begin
        job_q <= job_i;
        ex_q  <= 17'(job_i.wx) - 17'(job_i.vx);
        ey_q  <= 17'(job_i.wy) - 17'(job_i.vy);
        fx_q  <= 17'(job_i.px) - 17'(job_i.vx);
        fy_q  <= 17'(job_i.py) - 17'(job_i.vy);
      end
      S_L2B:   l2_q  <= prod_q[SQ_W-1:0];
      S_DOTA:  l2_q  <= l2_q + prod_q[SQ_W-1:0];
      S_DOTB:  dot_q <= prod_q[34:0];
      S_DOTC:  dot_q <= dot_q + prod_q[34:0];
      S_CLASS: begin
        if (clamp_v) begin
          qx_q <= 17'(job_q.vx);
          qy_q <= 17'(job_q.vy);
        end else if (clamp_w) begin
          qx_q <= 17'(job_q.wx);
          qy_q <= 17'(job_q.wy);
        end
      end
      S_NUMB:  num_q <= 50'(prod_q[33:0]);
      S_NUMC:  num_q <= num_q + {prod_q[32:0], 17'b0};
      S_NINIT: begin
        rem_q <= 36'(nfull[50:QUO_W]);
        low_q <= nfull[QUO_W-1:0];
        den_q <= {l2_q, 1'b0};
      end
      S_DIV: begin
        low_q <= {low_q[QUO_W-2:0], 1'b0};
        if (r_sh >= {1'b0, den_q}) begin
          rem_q <= r_sh - {1'b0, den_q};
          quo_q <= {quo_q[QUO_W-2:0], 1'b1};
        end else begin
          rem_q <= r_sh;
          quo_q <= {quo_q[QUO_W-2:0], 1'b0};
        end
      end
      S_OFS: begin
        if (axis_q) qy_q <= v_ax + ofs;
        else        qx_q <= v_ax + ofs;
      end
      S_DIST: begin
        dx_q <= 18'(job_q.px) - 18'(qx_q);
        dy_q <= 18'(job_q.py) - 18'(qy_q);
      end
      S_SQB:   d_q <= prod_q[34:0];
      S_SQC:   d_q <= d_q + prod_q[34:0];
      S_FIN: begin
        sv_q   <= best_q;
        sr_q   <= '0;
        root_q <= '0;
      end
      S_ROOT: begin
        sv_q <= {sv_q[SQ_W-3:0], 2'b00};
        if (sr_sh >= trial) begin
          sr_q   <= 19'(sr_sh - trial);
          root_q <= {root_q[DIST_W-2:0], 1'b1};
        end else begin
          sr_q   <= 19'(sr_sh);
          root_q <= {root_q[DIST_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
    if (load_out) begin
      min_q    <= job_q.no_seg ? '0 : root_q;
      idx_q    <= job_q.no_seg ? '0 : bidx_q;
      no_seg_q <= job_q.no_seg;
      ovf_q    <= job_q.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_FETCH;
      cnt_q       <= '0;
      axis_q      <= 1'b0;
      best_q      <= '1;
      bidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_NINIT || state_q == S_FIN) cnt_q <= '0;
      else if (state_q == S_DIV || state_q == S_ROOT) cnt_q <= cnt_q + 1'b1;
      if (state_q == S_CLASS) axis_q <= 1'b0;
      else if (state_q == S_OFS) axis_q <= 1'b1;
      if (state_q == S_CMP && d_q < {1'b0, best_q}) begin
        best_q <= d_q[SQ_W-1:0];
        bidx_q <= job_q.idx;
      end
      if (load_out) begin
        best_q      <= '1;
        bidx_q      <= '0;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign min_o       = min_q;
  assign idx_o       = idx_q;
  assign no_seg_o    = no_seg_q;
  assign ovf_o       = ovf_q;

  `PNS_ASSERT_IMP(a_div_cnt, state_q == S_DIV, cnt_q < 5'(QUO_W), "divider ran past its width")
  `PNS_ASSERT_IMP(a_empty_zero, out_valid_q && no_seg_q, min_q == '0 && idx_q == '0,
                  "empty polyline result not zero")
  `PNS_ASSERT_IMP(a_pop_fetch, pop_o, state_q == S_FETCH, "job taken outside fetch")

endmodule

/* src/polyline_nearest_segment.sv */
// Top level of the nearest polyline segment block
`timescale 1ns / 1ps
// Streams polyline vertices (query point with each vertex, signed Q8.8) and
// returns, on the vertex marked tlast, the floored distance to the nearest
// segment and that segment's index, or a no-segment flag. A front stage takes a
// vertex per cycle into a two-entry job queue while it is not full; the back
// stage works one job at a time on a single shared 18x18 multiplier and a
// one-bit-per-cycle divider. Clamped vertices skip the divider; one projecting
// inside runs it once per axis. The last vertex adds the 17-step square root
// and result load. Vertices past MAX_VERTICES are dropped and reported.
module polyline_nearest_segment import pns_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [63:0] s_axis_tdata_i,  // query_x, query_y, vertex_x, vertex_y
  input  logic        s_axis_tlast_i,  // last
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,  // min_distance, segment_index, zero fill
  output logic [1:0]  m_axis_tuser_o   // no_segment, overflow
);

  job_t              push_job, head_job;
  logic              push, full, head_valid, pop;
  logic [DIST_W-1:0] min_dist;
  logic [IDX_W-1:0]  seg_idx;
  logic              no_seg, ovf;

  pns_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .qx_i       (s_axis_tdata_i[15:0]),
    .qy_i       (s_axis_tdata_i[31:16]),
    .vx_i       (s_axis_tdata_i[47:32]),
    .vy_i       (s_axis_tdata_i[63:48]),
    .last_i     (s_axis_tlast_i),
    .push_o     (push),
    .job_o      (push_job),
    .full_i     (full)
  );

  pns_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_job)
  );

  pns_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .min_o       (min_dist),
    .idx_o       (seg_idx),
    .no_seg_o    (no_seg),
    .ovf_o       (ovf)
  );

  assign m_axis_tdata_o = {5'b0, seg_idx, min_dist};
  assign m_axis_tuser_o = {ovf, no_seg};

endmodule
